FILE: rtl/core/ilist_pkg.sv
// shared types and constants for the indexed ordered list
package ilist_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VAL_W    = 32;
   localparam int POS_W    = 9;
   localparam int MAG_W    = POS_W - 1;
   localparam int CMP_W    = ((CNT_W > MAG_W) ? CNT_W : MAG_W) + 1;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_INSERT     = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_POP_FRONT  = 3'd4,
      OP_REMOVE     = 3'd5
   } ilist_op_type;

   typedef enum logic [2:0] {
      ST_DONE     = 3'd0,
      ST_NEGATIVE = 3'd1,
      ST_REDIRECT = 3'd2,
      ST_FULL     = 3'd3,
      ST_EMPTY    = 3'd4
   } ilist_status_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic             apply;
      logic             ins;
      logic             rem;
      logic [IDX_W-1:0] idx;
      logic [CNT_W-1:0] new_count;
      logic [VAL_W-1:0] value;
   } ilist_cmd_type;

endpackage

FILE: rtl/core/ilist_ctrl.sv
// command decode and occupancy count for the indexed ordered list
module ilist_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [2:0]                    opcode,
   input  logic [ilist_pkg::VAL_W-1:0]   item_value,
   input  logic [ilist_pkg::POS_W-1:0]   position,
   output ilist_pkg::ilist_cmd_type      cmd,
   output ilist_pkg::ilist_status_type   status,
   output logic [ilist_pkg::CNT_W-1:0]   occupancy
);
   import ilist_pkg::*;

   logic [CNT_W-1:0] occupancy_ff;
   logic [CNT_W-1:0] occupancy_in;
   logic [CNT_W-1:0] occ_dec;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] occ_ext;
   logic             neg;
   logic             full;
   logic             empty;
   logic             ins;
   logic             rem;
   logic [IDX_W-1:0] idx;

   assign neg     = position[POS_W-1];
   assign pos_ext = CMP_W'(position[MAG_W-1:0]);
   assign occ_ext = CMP_W'(occupancy_ff);
   assign occ_dec = occupancy_ff - CNT_W'(1);
   assign full    = (occupancy_ff == CNT_W'(CAPACITY));
   assign empty   = (occupancy_ff == '0);

   always_comb begin
      ins    = 1'b0;
      rem    = 1'b0;
      idx    = '0;
      status = ST_DONE;
      case (ilist_op_type'(opcode))
         OP_PUSH_FRONT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               ins = 1'b1;
            end
         end
         OP_PUSH_BACK: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               ins = 1'b1;
               idx = IDX_W'(occupancy_ff);
            end
         end
         OP_INSERT: begin
            if (neg) begin
               status = ST_NEGATIVE;
            end else if (full) begin
               status = ST_FULL;
            end else if (pos_ext > occ_ext) begin
               ins    = 1'b1;
               idx    = IDX_W'(occupancy_ff);
               status = ST_REDIRECT;
            end else begin
               ins = 1'b1;
               idx = IDX_W'(position[MAG_W-1:0]);
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               rem = 1'b1;
               idx = IDX_W'(occ_dec);
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               rem = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (neg) begin
               status = ST_NEGATIVE;
            end else if (empty) begin
               status = ST_EMPTY;
            end else if ((pos_ext + CMP_W'(1)) >= occ_ext) begin
               rem = 1'b1;
               idx = IDX_W'(occ_dec);
            end else begin
               rem = 1'b1;
               idx = IDX_W'(position[MAG_W-1:0]);
            end
         end
         default: begin
            status = ST_DONE;
         end
      endcase
   end

   always_comb begin
      occupancy_in = occupancy_ff;
      if (accept && ins) begin
         occupancy_in = occupancy_ff + CNT_W'(1);
      end else if (accept && rem) begin
         occupancy_in = occ_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupancy_ff <= '0;
      end else begin
         occupancy_ff <= occupancy_in;
      end
   end

   assign cmd.apply     = accept;
   assign cmd.ins       = accept & ins;
   assign cmd.rem       = accept & rem;
   assign cmd.idx       = idx;
   assign cmd.new_count = occupancy_in;
   assign cmd.value     = item_value;
   assign occupancy     = occupancy_ff;

   a_occ_bounded: assert property (@(posedge clock) disable iff (reset)
      occupancy_ff <= CNT_W'(CAPACITY))
      else $error("occupancy above capacity");

   a_occ_step: assert property (@(posedge clock) disable iff (reset)
      (occupancy_ff != $past(occupancy_ff)) |->
         (occupancy_ff == $past(occupancy_ff) + CNT_W'(1) ||
          occupancy_ff == $past(occupancy_ff) - CNT_W'(1)))
      else $error("occupancy moved by more than one");

   a_no_add_when_full: assert property (@(posedge clock) disable iff (reset)
      (accept && full) |=> (occupancy_ff <= $past(occupancy_ff)))
      else $error("value added to a full list");

endmodule

FILE: rtl/core/ilist_cell.sv
// one storage cell of the list chain, shifts toward either neighbor
module ilist_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ilist_pkg::IDX_W-1:0] cell_idx,
   input  ilist_pkg::ilist_cmd_type    cmd,
   input  logic [ilist_pkg::VAL_W-1:0] left_value,
   input  logic [ilist_pkg::VAL_W-1:0] right_value,
   input  logic                        right_valid,
   output logic [ilist_pkg::VAL_W-1:0] value,
   output logic                        valid,
   output logic [ilist_pkg::VAL_W-1:0] tail_value
);
   import ilist_pkg::*;

   logic [VAL_W-1:0] value_ff;
   logic [VAL_W-1:0] value_in;
   logic             valid_ff;
   logic             valid_in;

   always_comb begin
      value_in = value_ff;
      if (cmd.ins) begin
         if (cell_idx > cmd.idx) begin
            value_in = left_value;
         end else if (cell_idx == cmd.idx) begin
            value_in = cmd.value;
         end
      end else if (cmd.rem) begin
         if (cell_idx >= cmd.idx) begin
            value_in = right_value;
         end
      end
   end

   // occupied cells always form a run starting at cell zero
   assign valid_in = cmd.apply ? (CNT_W'(cell_idx) < cmd.new_count) : valid_ff;

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value      = value_ff;
   assign valid      = valid_ff;
   assign tail_value = (valid_ff && !right_valid) ? value_ff : '0;

endmodule

FILE: rtl/core/indexed_ordered_list.sv
// indexed ordered list: top level with the cell chain and result stages
// result path: an accepted request is registered in stage_valid_ff, then rsp_strobe_ff raises the result strobe
// throughput: one request per cycle, busy stays low; each command shifts
//   all cells in parallel, the next cycle ORs the tail cell out
// reset clears the count, the cell valid bits and the result strobe
// results cannot be stalled, the receiver takes each one on its strobe
module indexed_ordered_list (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [2:0]                  req_opcode,
   input  logic [ilist_pkg::VAL_W-1:0] req_item_value,
   input  logic [ilist_pkg::POS_W-1:0] req_position,
   output logic                        rsp_strobe,
   output logic [2:0]                  rsp_status,
   output logic [ilist_pkg::CNT_W-1:0] rsp_entry_count,
   output logic [ilist_pkg::VAL_W-1:0] rsp_front_value,
   output logic [ilist_pkg::VAL_W-1:0] rsp_back_value
);
   import ilist_pkg::*;

   logic             accept;
   ilist_cmd_type    cmd;
   ilist_status_type status;
   logic [CNT_W-1:0] occupancy;

   logic [VAL_W-1:0] cell_value [CAPACITY];
   logic [VAL_W-1:0] cell_tail  [CAPACITY];
   logic [CAPACITY-1:0] cell_valid;
   logic [VAL_W-1:0] back_or;
   logic [VAL_W-1:0] front_sel;

   logic             stage_valid_ff;
   ilist_status_type stage_status_ff;
   logic [CNT_W-1:0] stage_count_ff;
   logic             rsp_strobe_ff;
   ilist_status_type rsp_status_ff;
   logic [CNT_W-1:0] rsp_count_ff;
   logic [VAL_W-1:0] rsp_front_ff;
   logic [VAL_W-1:0] rsp_back_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   ilist_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .opcode     (req_opcode),
      .item_value (req_item_value),
      .position   (req_position),
      .cmd        (cmd),
      .status     (status),
      .occupancy  (occupancy)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VAL_W-1:0] left_value;
      logic [VAL_W-1:0] right_value;
      logic             right_valid;

      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_mid
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = '0;
         assign right_valid = 1'b0;
      end else begin : g_inner
         assign right_value = cell_value[i+1];
         assign right_valid = cell_valid[i+1];
      end

      ilist_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_idx    (IDX_W'(i)),
         .cmd         (cmd),
         .left_value  (left_value),
         .right_value (right_value),
         .right_valid (right_valid),
         .value       (cell_value[i]),
         .valid       (cell_valid[i]),
         .tail_value  (cell_tail[i])
      );
   end

   // only the last occupied cell drives a nonzero tail value
   always_comb begin
      back_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         back_or = back_or | cell_tail[i];
      end
   end

   assign front_sel = cell_valid[0] ? cell_value[0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         stage_valid_ff <= accept;
         rsp_strobe_ff  <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      stage_status_ff <= status;
      stage_count_ff  <= cmd.new_count;
      rsp_status_ff   <= stage_status_ff;
      rsp_count_ff    <= stage_count_ff;
      rsp_front_ff    <= front_sel;
      rsp_back_ff     <= back_or;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_back_value  = rsp_back_ff;

   a_strobe_follows_request: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(accept, 2))
      else $error("result without a request");

   a_valid_run: assert property (@(posedge clock) disable iff (reset)
      (cell_valid & (cell_valid + CAPACITY'(1))) == '0)
      else $error("occupied cells not contiguous from the front");

   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(occupancy))
      else $error("cell valid bits disagree with occupancy");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_count_ff == '0) |->
         (rsp_front_ff == '0 && rsp_back_ff == '0))
      else $error("empty list reports nonzero ends");

endmodule
